// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the mask generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, masked while reset is asserted.
`define FFMG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("%m: check failed");
// Checked property, also during reset.
`define FFMG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define FFMG_ASSERT(lbl, clk, rst_n, prop)
`define FFMG_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/core/ffmg_pkg.sv -----
// Shared types, widths and constants of the frequency mask generator.
`default_nettype none
package ffmg_pkg;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int MASK_W    = 16;
    localparam int COORD_W   = 10;
    localparam int SIZE_W    = 11;
    localparam int CUT_W     = 19;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 19;
    localparam int DSQ_W     = 21;
    localparam int CSQ_W     = 38;
    localparam int DV_W      = 39;
    localparam int T_W       = 29;
    localparam int U_W       = 30;
    localparam int X_W       = 30;
    localparam int N_W       = 6;
    localparam int R_W       = 31;

    localparam int DIV_STEPS     = 29;
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
    localparam int DIV_LAT       = 1 + DIV_STAGES;
    localparam int HORNER_STEPS  = 8;
    localparam int EXP_LAT       = 2 + 3 * HORNER_STEPS + 1;
    localparam int FRONT_LAT     = 3;
    localparam int SIDE_LAT      = DIV_LAT + EXP_LAT;
    localparam int PIPE_LAT      = FRONT_LAT + DIV_LAT + EXP_LAT + 1;

    localparam logic [R_W-1:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [X_W-1:0] LN2_Q30   = 30'd744261118;
    localparam logic [R_W-1:0] ONE_Q30   = 31'd1073741824;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDEAL_LP = 3'd0,
        MODE_GAUSS_LP = 3'd1,
        MODE_IDEAL_HP = 3'd2,
        MODE_GAUSS_HP = 3'd3,
        MODE_IDEAL_BP = 3'd4,
        MODE_GAUSS_BP = 3'd5
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_INNER  = 3'd1,
        CFG_OUTER  = 3'd2,
        CFG_WIDTH  = 3'd3,
        CFG_HEIGHT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic lo_ok;
        logic hi_ok;
        logic bp_ok;
    } t_ideal;

    typedef struct packed {
        logic [T_W-1:0] t;
        logic           sat;
        logic           cut_zero;
        logic           d_zero;
    } t_quot;
endpackage
`default_nettype wire

// ----- rtl/core/ffmg_front.sv -----
// Distance from the image center, squared, and the ideal cutoff compares.
`default_nettype none
module ffmg_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [ffmg_pkg::COORD_W-1:0]  i_col_x,
    input  wire logic [ffmg_pkg::COORD_W-1:0]  i_row_y,
    input  wire logic [ffmg_pkg::SIZE_W-1:0]   i_width,
    input  wire logic [ffmg_pkg::SIZE_W-1:0]   i_height,
    input  wire logic [ffmg_pkg::CUT_W-1:0]    i_inner,
    input  wire logic [ffmg_pkg::CUT_W-1:0]    i_outer,
    output logic      [ffmg_pkg::DSQ_W-1:0]    o_dsq,
    output ffmg_pkg::t_ideal                   o_ideal
);
    import ffmg_pkg::*;

    logic [COORD_W-1:0] cx, cy, adx, ady;
    logic [COORD_W-1:0] r_adx, r_ady;
    logic [CSQ_W-1:0]   r_c1sq, r_c2sq, r_c1sq2, r_c2sq2;
    logic [DSQ_W-1:0]   r_dsq, r_dsq3;
    logic [CSQ_W-1:0]   dsq16;
    t_ideal             r_ideal;

    assign cx  = i_width[SIZE_W-1:1];
    assign cy  = i_height[SIZE_W-1:1];
    assign adx = (i_col_x >= cx) ? (i_col_x - cx) : (cx - i_col_x);
    assign ady = (i_row_y >= cy) ? (i_row_y - cy) : (cy - i_row_y);
    assign dsq16 = {1'b0, r_dsq, 16'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_adx   <= adx;
            r_ady   <= ady;
            r_c1sq  <= CSQ_W'(i_inner) * CSQ_W'(i_inner);
            r_c2sq  <= CSQ_W'(i_outer) * CSQ_W'(i_outer);
            r_dsq   <= DSQ_W'(r_adx * r_adx) + DSQ_W'(r_ady * r_ady);
            r_c1sq2 <= r_c1sq;
            r_c2sq2 <= r_c2sq;
            r_dsq3  <= r_dsq;
            r_ideal.lo_ok <= (dsq16 <= r_c1sq2);
            r_ideal.hi_ok <= (dsq16 >= r_c1sq2);
            r_ideal.bp_ok <= (dsq16 >= r_c1sq2) && (dsq16 <= r_c2sq2);
        end
    end

    assign o_dsq   = r_dsq3;
    assign o_ideal = r_ideal;
endmodule
`default_nettype wire

// ----- rtl/core/ffmg_div.sv -----
// Pipelined restoring divider: t = (dsq << 40) / (2 * cut^2), saturating at 32.0.
`default_nettype none
module ffmg_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [ffmg_pkg::DSQ_W-1:0]  i_dsq,
    input  wire logic [ffmg_pkg::CUT_W-1:0]  i_cut,
    output ffmg_pkg::t_quot                  o_quot
);
    import ffmg_pkg::*;

    logic [DV_W-1:0]  r_dv;
    logic [DV_W-1:0]  r_rem [DIV_STAGES+1];
    logic [T_W-1:0]   r_q   [DIV_STAGES+1];
    logic [DIV_STAGES:0] r_sat, r_cz, r_dz;
    logic [DV_W-1:0]  rem0;

    // Divisor tracks cut; users keep it stable with words in flight, unchecked.
    always_ff @(posedge i_clk) begin
        r_dv <= {CSQ_W'(i_cut) * CSQ_W'(i_cut), 1'b0};
    end

    // The low 40 numerator bits are zero, so start from dsq << 11.
    assign rem0 = DV_W'({i_dsq, 11'b0});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= rem0;
            r_q[0]   <= '0;
            r_sat[0] <= (rem0 >= r_dv);
            r_cz[0]  <= (i_cut == '0);
            r_dz[0]  <= (i_dsq == '0);
        end
    end

    for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_stage
        logic [DV_W-1:0] rem_n;
        logic [T_W-1:0]  q_n;

        always_comb begin
            logic [DV_W:0]   sh;
            logic [DV_W-1:0] rem;
            logic [T_W-1:0]  q;
            rem = r_rem[j-1];
            q   = r_q[j-1];
            sh  = '0;
            for (int p = 0; p < DIV_PER_STAGE; p++) begin
                if ((j - 1) * DIV_PER_STAGE + p < DIV_STEPS) begin
                    sh = {rem, 1'b0};
                    if (sh >= {1'b0, r_dv}) begin
                        sh = sh - {1'b0, r_dv};
                        q  = {q[T_W-2:0], 1'b1};
                    end else begin
                        q  = {q[T_W-2:0], 1'b0};
                    end
                    rem = sh[DV_W-1:0];
                end
            end
            rem_n = rem;
            q_n   = q;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= rem_n;
                r_q[j]   <= q_n;
                r_sat[j] <= r_sat[j-1];
                r_cz[j]  <= r_cz[j-1];
                r_dz[j]  <= r_dz[j-1];
            end
        end
    end

    assign o_quot.t        = r_q[DIV_STAGES];
    assign o_quot.sat      = r_sat[DIV_STAGES];
    assign o_quot.cut_zero = r_cz[DIV_STAGES];
    assign o_quot.d_zero   = r_dz[DIV_STAGES];
endmodule
`default_nettype wire

// ----- rtl/core/ffmg_exp.sv -----
// Pipelined exp(-t): base-2 split, Horner series for the fraction, rounding shift.
`default_nettype none
module ffmg_exp #(
    parameter int OUT_FRAC_BITS = ffmg_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  ffmg_pkg::t_quot          i_quot,
    output logic [OUT_FRAC_BITS:0]   o_g
);
    import ffmg_pkg::*;

    localparam int GW    = OUT_FRAC_BITS + 1;
    localparam int S_ADD = 30 - OUT_FRAC_BITS;
    localparam int NSIDE = 3 * HORNER_STEPS + 1;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [N_W-1:0] n;
        logic           sat;
        logic           cz;
        logic           dz;
    } t_exp_side;

    logic [U_W-1:0] r_u;
    logic           r_sat1, r_cz1, r_dz1;
    logic [2*U_W-1:0] prod_u, prod_x;
    t_exp_side      r_side [NSIDE];
    logic [R_W-1:0] w_r    [HORNER_STEPS+1];
    logic [R_W-1:0] r_rv   [HORNER_STEPS];
    logic [X_W-1:0] r_pa   [HORNER_STEPS];
    logic [X_W-1:0] r_pb   [HORNER_STEPS];
    logic [X_W-1:0] r_q0   [HORNER_STEPS];
    logic [GW-1:0]  r_g;
    logic [6:0]     s;
    logic [31:0]    rsum;
    logic [GW-1:0]  g_n;
    t_exp_side      last;

    assign prod_u = 60'(i_quot.t) * 60'(LOG2E_Q30);
    assign prod_x = 60'({r_u[23:0], 6'b0}) * 60'(LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u    <= prod_u[59:30];
            r_sat1 <= i_quot.sat;
            r_cz1  <= i_quot.cut_zero;
            r_dz1  <= i_quot.d_zero;
            r_side[0].x   <= prod_x[59:30];
            r_side[0].n   <= r_u[29:24];
            r_side[0].sat <= r_sat1;
            r_side[0].cz  <= r_cz1;
            r_side[0].dz  <= r_dz1;
        end
    end

    assign w_r[0] = ONE_Q30;

    for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
        localparam int K = HORNER_STEPS - i;
        localparam logic [31:0] M = 32'((64'd1 << 32) / K);
        logic [60:0] pa;
        logic [61:0] pb;
        logic [32:0] rem;
        logic [X_W-1:0] q;

        assign pa  = 61'(r_side[3*i].x) * 61'(w_r[i]);
        assign pb  = 62'(r_pa[i]) * 62'(M);
        assign rem = 33'(r_pb[i]) - 33'(r_q0[i]) * 33'(K);
        assign q   = r_q0[i] + X_W'(rem >= 33'(K));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pa[i] <= pa[59:30];
                r_pb[i] <= r_pa[i];
                if (K == 1) begin
                    r_q0[i] <= r_pa[i];
                end else begin
                    r_q0[i] <= pb[61:32];
                end
                r_rv[i] <= ONE_Q30 - R_W'(q);
                r_side[3*i+1] <= r_side[3*i];
                r_side[3*i+2] <= r_side[3*i+1];
                r_side[3*i+3] <= r_side[3*i+2];
            end
        end

        assign w_r[i+1] = r_rv[i];
    end

    assign last = r_side[NSIDE-1];
    assign s    = 7'(last.n) + 7'(S_ADD);
    assign rsum = 32'(w_r[HORNER_STEPS]) + (32'd1 << (s[4:0] - 5'd1));

    always_comb begin
        priority if (last.cz) begin
            g_n = last.dz ? (GW'(1) << OUT_FRAC_BITS) : '0;
        end else if (last.sat) begin
            g_n = '0;
        end else if (s == '0) begin
            g_n = GW'(w_r[HORNER_STEPS]);
        end else if (s >= 7'd32) begin
            g_n = '0;
        end else begin
            g_n = GW'(rsum >> s[4:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g <= g_n;
        end
    end

    assign o_g = r_g;
endmodule
`default_nettype wire

// ----- rtl/core/frequency_filter_mask_gen_unit.sv -----
// Top level of the frequency mask generator: registers, pipeline and mode select.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------
//  in      | to unit   | i_in_valid / o_in_ready     | i_col_x, i_row_y
//  out     | from unit | o_out_valid / i_out_ready   | o_mask_value (Q2.14)
//  cfg     | to unit   | i_cfg_we (no wait)          | i_cfg_idx, i_cfg_wdata
//
// One word enters per cycle unless the output is held. The pipeline depth comes mostly from
// the 15-stage restoring divider (two quotient bits per stage) and the
// eight Horner steps of the exp series, three stages each.
// Reset is synchronous and active low; it clears the valid line and loads the
// register defaults. There is no clearing pass.
// A held output freezes the whole pipeline in place; ready drops only while
// the last stage holds a word that is not taken.
`default_nettype none
module frequency_filter_mask_gen_unit #(
    parameter int OUT_FRAC_BITS = ffmg_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [ffmg_pkg::COORD_W-1:0]       i_col_x,
    input  wire logic [ffmg_pkg::COORD_W-1:0]       i_row_y,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [ffmg_pkg::MASK_W-1:0]      o_mask_value,
    input  wire logic                               i_cfg_we,
    input  wire logic [ffmg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ffmg_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import ffmg_pkg::*;
    `include "assert_macros.svh"

    localparam int GW = OUT_FRAC_BITS + 1;
    localparam int VW = GW + 2;
    localparam logic signed [VW-1:0] ONE_V = VW'(1) << OUT_FRAC_BITS;
    localparam logic signed [MASK_W-1:0] ONE_M = MASK_W'(ONE_V);

    logic [MODE_W-1:0] r_filter_mode;
    logic [CUT_W-1:0]  r_inner_cutoff, r_outer_cutoff;
    logic [SIZE_W-1:0] r_image_width, r_image_height;

    logic                en;
    logic [PIPE_LAT-1:0] r_vld;
    logic [DSQ_W-1:0]    dsq;
    t_ideal              ideal;
    t_ideal              r_idl [SIDE_LAT];
    t_quot               quot_in, quot_out;
    logic [GW-1:0]       g_in, g_out;
    logic signed [VW-1:0] v, ext_in, ext_out;
    logic signed [MASK_W-1:0] r_mask;
    logic                is_ideal;

    // Register file: plain writes, no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode  <= MODE_IDEAL_LP;
            r_inner_cutoff <= 19'd8192;
            r_outer_cutoff <= 19'd16384;
            r_image_width  <= 11'd256;
            r_image_height <= 11'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:   r_filter_mode  <= i_cfg_wdata[MODE_W-1:0];
                CFG_INNER:  r_inner_cutoff <= i_cfg_wdata;
                CFG_OUTER:  r_outer_cutoff <= i_cfg_wdata;
                CFG_WIDTH:  r_image_width  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_HEIGHT: r_image_height <= i_cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance everything unless the output word is held.
    assign en         = !r_vld[PIPE_LAT-1] || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid};
        end
    end

    ffmg_front u_front (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_col_x  (i_col_x),
        .i_row_y  (i_row_y),
        .i_width  (r_image_width),
        .i_height (r_image_height),
        .i_inner  (r_inner_cutoff),
        .i_outer  (r_outer_cutoff),
        .o_dsq    (dsq),
        .o_ideal  (ideal)
    );

    ffmg_div u_div_in (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_dsq  (dsq),
        .i_cut  (r_inner_cutoff),
        .o_quot (quot_in)
    );

    ffmg_div u_div_out (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_dsq  (dsq),
        .i_cut  (r_outer_cutoff),
        .o_quot (quot_out)
    );

    ffmg_exp #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_exp_in (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_quot (quot_in),
        .o_g    (g_in)
    );

    ffmg_exp #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_exp_out (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_quot (quot_out),
        .o_g    (g_out)
    );

    // Hold the ideal compares beside the Gaussian path.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_idl[0] <= ideal;
            for (int i = 1; i < SIDE_LAT; i++) begin
                r_idl[i] <= r_idl[i-1];
            end
        end
    end

    assign ext_in  = VW'(g_in);
    assign ext_out = VW'(g_out);

    always_comb begin
        unique case (r_filter_mode)
            MODE_IDEAL_LP: v = r_idl[SIDE_LAT-1].lo_ok ? ONE_V : '0;
            MODE_GAUSS_LP: v = ext_in;
            MODE_IDEAL_HP: v = r_idl[SIDE_LAT-1].hi_ok ? ONE_V : '0;
            MODE_GAUSS_HP: v = ONE_V - ext_in;
            MODE_IDEAL_BP: v = r_idl[SIDE_LAT-1].bp_ok ? ONE_V : '0;
            MODE_GAUSS_BP: v = ext_out - ext_in;
            default:       v = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mask <= MASK_W'(v);
        end
    end

    assign o_out_valid  = r_vld[PIPE_LAT-1];
    assign o_mask_value = r_mask;

    assign is_ideal = (r_filter_mode == MODE_IDEAL_LP) || (r_filter_mode == MODE_IDEAL_HP)
                      || (r_filter_mode == MODE_IDEAL_BP);

    `FFMG_ASSERT_ALWAYS(a_rst_clears, i_clk, !i_rst_n |=> !o_out_valid)
    `FFMG_ASSERT(a_accept_enters, i_clk, i_rst_n, i_in_valid && o_in_ready |=> r_vld[0])
    `FFMG_ASSERT(a_stall_freezes, i_clk, i_rst_n, !o_in_ready |=> $stable(r_vld))
    `FFMG_ASSERT(a_ideal_binary, i_clk, i_rst_n, o_out_valid && is_ideal |-> (o_mask_value == '0 || o_mask_value == ONE_M))
endmodule
`default_nettype wire

// ----- sim/frequency_filter_mask_gen_unit_tb.sv -----
// Self-checking testbench for the mask generator: directed cases, random coordinates, settings.
`default_nettype none
module frequency_filter_mask_gen_unit_tb;
    import ffmg_pkg::*;

    localparam int TAIL_CYCLES = PIPE_LAT + 20;
    localparam int STALL_LIMIT = 20000;

    // Scoreboard: predict each mask weight and hold expectations in order.
    class mask_scoreboard;
        logic [MODE_W-1:0] mode;
        logic [CUT_W-1:0]  inner_cut;
        logic [CUT_W-1:0]  outer_cut;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [15:0]       pending_weights[$];
        int                errors;

        function new();
            mode      = MODE_IDEAL_LP;
            inner_cut = 19'd8192;
            outer_cut = 19'd16384;
            width     = 11'd256;
            height    = 11'd256;
            errors    = 0;
        endfunction

        // Gaussian weight exp(-d^2 / 2c^2) in Q14.
        function automatic longint gauss_q14(longint unsigned dsq, logic [CUT_W-1:0] cut);
            longint unsigned c2, t, u, f, x, r, s;
            int k;
            if (cut == 0) return (dsq == 0) ? 64'd16384 : 64'd0;
            c2 = longint'(cut) * longint'(cut);
            t = (dsq << 40) / (2 * c2);
            if (t >= (64'd32 << 24)) return 0;
            u = (t * 64'd1549082005) >> 30;
            f = u & ((64'd1 << 24) - 1);
            x = ((f << 6) * 64'd744261118) >> 30;
            r = 64'd1 << 30;
            for (k = 8; k >= 1; k--)
                r = (64'd1 << 30) - ((x * r) >> 30) / k;
            s = (u >> 24) + 30 - 14;
            if (s == 0) return longint'(r);
            return longint'((r + (64'd1 << (s - 1))) >> s);
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_MODE:   mode      = val[MODE_W-1:0];
                CFG_INNER:  inner_cut = val[CUT_W-1:0];
                CFG_OUTER:  outer_cut = val[CUT_W-1:0];
                CFG_WIDTH:  width     = val[SIZE_W-1:0];
                CFG_HEIGHT: height    = val[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_coord(logic [COORD_W-1:0] cx_in, logic [COORD_W-1:0] ry_in);
            longint unsigned cx, cy, adx, ady, dsq, d16, c1, c2;
            longint v;
            cx = width >> 1;
            cy = height >> 1;
            adx = (cx_in >= cx) ? cx_in - cx : cx - cx_in;
            ady = (ry_in >= cy) ? ry_in - cy : cy - ry_in;
            dsq = adx * adx + ady * ady;
            d16 = dsq << 16;
            c1 = longint'(inner_cut) * longint'(inner_cut);
            c2 = longint'(outer_cut) * longint'(outer_cut);
            case (mode)
                MODE_IDEAL_LP: v = (d16 <= c1) ? 16384 : 0;
                MODE_GAUSS_LP: v = gauss_q14(dsq, inner_cut);
                MODE_IDEAL_HP: v = (d16 >= c1) ? 16384 : 0;
                MODE_GAUSS_HP: v = 16384 - gauss_q14(dsq, inner_cut);
                MODE_IDEAL_BP: v = (d16 >= c1 && d16 <= c2) ? 16384 : 0;
                MODE_GAUSS_BP: v = gauss_q14(dsq, outer_cut) - gauss_q14(dsq, inner_cut);
                default:       v = 0;
            endcase
            pending_weights.push_back(v[15:0]);
        endfunction

        function void check_weight(logic [15:0] got);
            logic [15:0] want;
            if (pending_weights.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %0d", $time,
                         $signed(got));
                errors++;
                return;
            end
            want = pending_weights.pop_front();
            if (got !== want) begin
                $display("%0t: mask_value mismatch, expected %0d, actual %0d", $time,
                         $signed(want), $signed(got));
                errors++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [COORD_W-1:0]          col_x;
    logic [COORD_W-1:0]          row_y;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [MASK_W-1:0]    mask_value;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_idx;
    logic [CFG_W-1:0]            cfg_wdata;

    mask_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  quiet_cycles;
    int  rand_left;

    frequency_filter_mask_gen_unit u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_col_x      (col_x),
        .i_row_y      (row_y),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_mask_value (mask_value),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver: stall at random, check every word taken.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_weight(mask_value);
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: count cycles with no word moving on either channel.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Present one coordinate after a random gap; hold until taken. Valid stays
    // high afterwards so the next word can follow; the idle gap or drain drops it.
    task automatic send_coord(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        col_x    <= x;
        row_y    <= y;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_coord(x, y);
    endtask

    // Drop valid and wait for the pipeline to drain, plus a tail longer than its latency.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_weights.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    // Pick a cutoff: extremes sometimes, mostly near the image scale.
    function automatic logic [CFG_W-1:0] pick_cut();
        case ($urandom_range(5))
            0:       return 19'd0;
            1:       return 19'h7FFFF;
            2:       return CFG_W'($urandom_range(255));
            default: return CFG_W'($urandom_range(100 * 256));
        endcase
    endfunction

    task automatic random_settings();
        write_cfg(CFG_MODE, CFG_W'($urandom_range(7)));
        write_cfg(CFG_INNER, pick_cut());
        write_cfg(CFG_OUTER, pick_cut());
        write_cfg(CFG_WIDTH, CFG_W'(($urandom_range(3) == 0) ? $urandom_range(2047)
                                                             : $urandom_range(2, 200)));
        write_cfg(CFG_HEIGHT, CFG_W'(($urandom_range(3) == 0) ? $urandom_range(2047)
                                                              : $urandom_range(2, 200)));
    endtask

    // Coordinates: mostly near the centre so cutoff edges get hit, some anywhere.
    task automatic send_random_coord();
        int cx, cy;
        cx = int'(sb.width >> 1);
        cy = int'(sb.height >> 1);
        if ($urandom_range(3) == 0)
            send_coord(COORD_W'($urandom), COORD_W'($urandom));
        else
            send_coord(COORD_W'(cx + $urandom_range(64) - 32),
                       COORD_W'(cy + $urandom_range(64) - 32));
    endtask

    initial begin
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        col_x         = '0;
        row_y         = '0;
        out_ready     = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_MODE;
        cfg_wdata     = '0;
        quiet_cycles  = 0;
        send_idle_pct = 6;
        recv_idle_pct = 80;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset defaults, corners and centre, then each mode.
        send_coord(10'd128, 10'd128);
        send_coord(10'd0, 10'd0);
        send_coord(10'h3FF, 10'h3FF);
        send_coord(10'd160, 10'd128);
        send_coord(10'd192, 10'd128);
        for (int m = 0; m < 8; m++) begin
            drain();
            write_cfg(CFG_MODE, CFG_W'(m));
            send_coord(10'd128, 10'd128);
            send_coord(10'd150, 10'd140);
            send_coord(10'h3FF, 10'd0);
        end
        drain();
        // Zero inner cutoff, a one-column image (centre column 0), inner above outer.
        write_cfg(CFG_INNER, 19'd0);
        write_cfg(CFG_OUTER, 19'h7FFFF);
        write_cfg(CFG_WIDTH, 11'd1);
        write_cfg(CFG_HEIGHT, 11'h7FF);
        write_cfg(CFG_MODE, CFG_W'(MODE_GAUSS_BP));
        send_coord(10'd0, 10'd1023);
        send_coord(10'd0, 10'd5);
        drain();
        write_cfg(CFG_MODE, CFG_W'(MODE_GAUSS_HP));
        send_coord(10'd0, 10'd1023);
        drain();
        write_cfg(CFG_INNER, 19'd4096);
        write_cfg(CFG_OUTER, 19'd512);
        write_cfg(CFG_WIDTH, 11'd2);
        write_cfg(CFG_HEIGHT, 11'd2);
        write_cfg(CFG_MODE, CFG_W'(MODE_GAUSS_BP));
        send_coord(10'd4, 10'd1);
        drain();
        write_cfg(CFG_MODE, CFG_W'(MODE_IDEAL_BP));
        send_coord(10'd4, 10'd1);
        drain();
        write_cfg(CFG_MODE, CFG_W'(MODE_IDEAL_LP));
        send_coord(10'd1, 10'd1);
        drain();

        // Random phases: three idling profiles, new settings every 47 words.
        rand_left = 850;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 80 : 0;
            recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 6 : 0;
            for (int b = 0; b < 6 && rand_left > 0; b++) begin
                drain();
                random_settings();
                for (int i = 0; i < 47 && rand_left > 0; i++) begin
                    send_random_coord();
                    rand_left--;
                end
            end
        end
        while (rand_left > 0) begin
            send_random_coord();
            rand_left--;
        end

        drain();
        if (sb.errors == 0 && sb.pending_weights.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
